@@ src/kmp_pattern_matcher_unit_macros.svh @@
// ----------------------------------------------------------------------------
// kmp pattern matcher assertion macros
// concurrent assertion shorthands, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef KMP_PATTERN_MATCHER_UNIT_MACROS_SVH
`define KMP_PATTERN_MATCHER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmp matcher: same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmp matcher: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/kmp_pkg.sv @@
// ----------------------------------------------------------------------------
// kmp_pkg
// shared widths, register indexes, controller interface types and a pattern byte helper
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

   localparam int unsigned PATTERN_MAX_DEF   = 16;
   localparam int unsigned POSITION_BITS_DEF = 32;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned COUNT_W           = 5;
   localparam int unsigned WORD_W            = 64;
   localparam int unsigned OFFSET_W          = 32;
   localparam int unsigned CSR_INDEX_W       = 2;
   localparam int unsigned PAT_IDX_W         = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic build_start;
      logic build_step;
      logic accept;
      logic fall;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cfg_hit;
      logic build_done;
      logic fall_pending;
      logic out_free;
   } ctrl_sts_type;

   function automatic logic [BYTE_W-1:0] pattern_byte(
      input logic [2*WORD_W-1:0] pattern,
      input logic [PAT_IDX_W-1:0] idx
   );
      return pattern[idx*BYTE_W +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

@@ src/kmp_datapath.sv @@
// ----------------------------------------------------------------------------
// kmp_datapath
// pattern registers, failure table, match state and result register
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_datapath #(
   parameter int unsigned PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
   parameter int unsigned POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire kmp_pkg::ctrl_cmd_type                cmd,
   output kmp_pkg::ctrl_sts_type                     sts,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [kmp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [kmp_pkg::WORD_W-1:0]           csr_data,
   input  wire logic [kmp_pkg::BYTE_W-1:0]           req_tdata,
   input  wire logic                                 req_tuser,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tvalid,
   output logic [kmp_pkg::OFFSET_W-1:0]              rsp_tdata,
   output logic                                      rsp_tuser
);

   localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [kmp_pkg::COUNT_W-1:0] ONE     = kmp_pkg::COUNT_W'(1);
   localparam logic [kmp_pkg::COUNT_W-1:0] LEN_MAX = kmp_pkg::COUNT_W'(PATTERN_MAX);

   logic [kmp_pkg::WORD_W-1:0]  pat_low_ff,  pat_low_in;
   logic [kmp_pkg::WORD_W-1:0]  pat_high_ff, pat_high_in;
   logic [kmp_pkg::COUNT_W-1:0] pat_len_ff,  pat_len_in;
   logic [kmp_pkg::COUNT_W-1:0] fail_ff [PATTERN_MAX];
   logic [kmp_pkg::COUNT_W-1:0] fail_in [PATTERN_MAX];
   logic [kmp_pkg::COUNT_W-1:0] pre_ff, pre_in;
   logic [kmp_pkg::COUNT_W-1:0] cur_ff, cur_in;
   logic [kmp_pkg::COUNT_W-1:0] match_ff, match_in;
   logic [kmp_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic [POSITION_BITS-1:0]    pos_ff, pos_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [kmp_pkg::OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic [2*kmp_pkg::WORD_W-1:0] pattern;
   logic [kmp_pkg::COUNT_W-1:0]  eff_len;
   logic                         match_eq;
   logic                         fall;
   logic [kmp_pkg::COUNT_W-1:0]  rd_full;
   logic [IDX_W-1:0]             rd_idx;
   logic [kmp_pkg::COUNT_W-1:0]  rd_val;
   logic [IDX_W-1:0]             wr_idx;
   logic [kmp_pkg::COUNT_W-1:0]  match_hit;
   logic [POSITION_BITS-1:0]     off_full;
   logic                         csr_we;
   logic                         cfg_hit;

   assign pattern   = {pat_high_ff, pat_low_ff};
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign cfg_hit   = csr_we && (csr_index == kmp_pkg::REG_PATTERN_LOW ||
                                 csr_index == kmp_pkg::REG_PATTERN_HIGH ||
                                 csr_index == kmp_pkg::REG_PATTERN_LENGTH);

   always_comb begin
      if (pat_len_ff == '0) begin
         eff_len = ONE;
      end else if (pat_len_ff > LEN_MAX) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = pat_len_ff;
      end
   end

   assign match_eq =
      kmp_pkg::pattern_byte(pattern, match_ff[kmp_pkg::PAT_IDX_W-1:0]) == byte_ff;
   assign fall      = (match_ff != '0) && !match_eq;
   assign match_hit = match_ff + (match_eq ? ONE : '0);
   assign off_full  = pos_ff + POSITION_BITS'(1) - POSITION_BITS'(eff_len);

   // single read port of the failure table
   always_comb begin
      if (cmd.build_step) begin
         rd_full = pre_ff - ONE;
      end else if (fall) begin
         rd_full = match_ff - ONE;
      end else begin
         rd_full = eff_len - ONE;
      end
   end

   assign rd_idx = rd_full[IDX_W-1:0];
   assign rd_val = fail_ff[rd_idx];
   assign wr_idx = cur_ff[IDX_W-1:0];

   always_comb begin
      sts.cfg_hit      = cfg_hit;
      sts.build_done   = cur_ff >= eff_len;
      sts.fall_pending = fall;
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      logic [kmp_pkg::BYTE_W-1:0] cur_byte;
      logic [kmp_pkg::BYTE_W-1:0] pre_byte;
      cur_byte      = kmp_pkg::pattern_byte(pattern, cur_ff[kmp_pkg::PAT_IDX_W-1:0]);
      pre_byte      = kmp_pkg::pattern_byte(pattern, pre_ff[kmp_pkg::PAT_IDX_W-1:0]);
      pat_low_in    = pat_low_ff;
      pat_high_in   = pat_high_ff;
      pat_len_in    = pat_len_ff;
      fail_in       = fail_ff;
      pre_in        = pre_ff;
      cur_in        = cur_ff;
      match_in      = match_ff;
      byte_in       = byte_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;

      if (csr_we) begin
         unique case (csr_index)
            kmp_pkg::REG_PATTERN_LOW:    pat_low_in  = csr_data;
            kmp_pkg::REG_PATTERN_HIGH:   pat_high_in = csr_data;
            kmp_pkg::REG_PATTERN_LENGTH: pat_len_in  = csr_data[kmp_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.build_start) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            fail_in[i] = '0;
         end
         pre_in   = '0;
         cur_in   = ONE;
         match_in = '0;
      end else if (cmd.build_step) begin
         if (cur_byte == pre_byte) begin
            pre_in          = pre_ff + ONE;
            fail_in[wr_idx] = pre_ff + ONE;
            cur_in          = cur_ff + ONE;
         end else if (pre_ff != '0) begin
            pre_in = rd_val;
         end else begin
            fail_in[wr_idx] = '0;
            cur_in          = cur_ff + ONE;
         end
      end else if (cmd.accept) begin
         byte_in = req_tdata;
         if (req_tuser) begin
            pos_in = '0;
         end
         if (req_tuser || match_ff >= eff_len) begin
            match_in = '0;
         end
      end else if (cmd.fall) begin
         match_in = rd_val;
      end else if (cmd.finish) begin
         pos_in       = pos_ff + POSITION_BITS'(1);
         rsp_valid_in = 1'b1;
         if (match_hit == eff_len) begin
            rsp_found_in  = 1'b1;
            rsp_offset_in = kmp_pkg::OFFSET_W'(off_full);
            match_in      = rd_val;
         end else begin
            rsp_found_in  = 1'b0;
            rsp_offset_in = '0;
            match_in      = match_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= ONE;
         for (int i = 0; i < PATTERN_MAX; i++) begin
            fail_ff[i] <= '0;
         end
         pre_ff       <= '0;
         cur_ff       <= ONE;
         match_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         pat_len_ff   <= pat_len_in;
         fail_ff      <= fail_in;
         pre_ff       <= pre_in;
         cur_ff       <= cur_in;
         match_ff     <= match_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff       <= byte_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

endmodule

`default_nettype wire

@@ src/kmp_controller.sv @@
// ----------------------------------------------------------------------------
// kmp_controller
// sequences table build, byte intake, fallback steps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kmp_pkg::ctrl_sts_type sts,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output kmp_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_BUILD,
      ST_IDLE,
      ST_MATCH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ST_IDLE) && !sts.cfg_hit;
      if (sts.cfg_hit) begin
         cmd.build_start = 1'b1;
         state_in        = ST_BUILD;
      end else begin
         unique case (state_ff)
            ST_BUILD: begin
               if (sts.build_done) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.build_step = 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd.accept = 1'b1;
                  state_in   = ST_MATCH;
               end
            end
            ST_MATCH: begin
               if (sts.fall_pending) begin
                  cmd.fall = 1'b1;
               end else if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_BUILD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BUILD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/kmp_pattern_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_unit: streaming knuth-morris-pratt matcher, one beat out per byte
// per byte: intake, then failure-table fallbacks while the byte mismatches, then the result
// write when the output is free; the next byte is taken only after that result is written
// reset: zero pattern, length 1; no beats are taken during table build cycles
// ----------------------------------------------------------------------------
`default_nettype none

`include "kmp_pattern_matcher_unit_macros.svh"

module kmp_pattern_matcher_unit #(
   parameter int unsigned PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
   parameter int unsigned POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [kmp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kmp_pkg::WORD_W-1:0]       csr_data,
   // text stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [kmp_pkg::BYTE_W-1:0]       req_tdata,  // text_byte
   input  wire logic                             req_tuser,  // text_start
   // match results
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [kmp_pkg::OFFSET_W-1:0]          rsp_tdata,  // match_offset
   output logic                                  rsp_tuser   // match_found
);

   kmp_pkg::ctrl_cmd_type cmd;
   kmp_pkg::ctrl_sts_type sts;

   kmp_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   kmp_datapath #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_IMPLIES(a_finish_has_slot, clock, reset, cmd.finish, sts.out_free)
   `ASSERT_NEXT(a_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_NEXT(a_build_after_write, clock, reset, sts.cfg_hit, !req_tready)

endmodule

`default_nettype wire

@@ dv/kmp_pattern_matcher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_unit_tb: self-checking bench for the streaming kmp matcher
// A short table of directed beats and pattern writes runs first: reset values,
// all-ones and all-zero patterns, the length clamps, overlapping matches, an
// unused register index and a pattern rewrite in the middle of a text. Then
// random phases follow. Each phase writes a new pattern, mostly from a two- or
// three-letter alphabet, and streams text built from pattern copies, some of
// them broken, mixed with alphabet and noise bytes. A predictor keeps its own
// failure table, match count and text position and checks every result beat.
// Both sides idle and stall at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kmp_pkg::*;

   localparam int unsigned TEXT_ITEMS  = 900;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_WAIT  = 64;
   localparam int unsigned PRINT_LIMIT = 50;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic {ROW_TEXT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [WORD_W-1:0]       data;
      logic [BYTE_W-1:0]       text;
      logic                    start;
      logic                    typed;
      logic                    found;
      logic [OFFSET_W-1:0]     offset;
   } dir_row_type;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_W-1:0]     offset;
   } match_result_type;

   // kind, index, data, text, start, typed, found, offset
   localparam dir_row_type DIRECTED_ROWS [25] = '{
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd2},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_CSR,  REG_SPARE, 64'hA5A5_5A5A_C3C3_3C3C, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd1},
      '{ROW_CSR,  REG_PATTERN_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_CSR,  REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_CSR,  REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFE, 1'b0, 1'b1, 1'b0, 32'd0},
      // upper bits of the length word are dropped
      '{ROW_CSR,  REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE2, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd2},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd3},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h7F, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
      // rewrite mid text drops the partial match, position runs on
      '{ROW_CSR,  REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd7},
      '{ROW_CSR,  REG_PATTERN_LOW, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_CSR,  REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT, REG_PATTERN_LOW, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0, 32'd0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [WORD_W-1:0]       csr_data = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [BYTE_W-1:0]       req_tdata = '0;   // text_byte
   logic                    req_tuser = 1'b0; // text_start
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [OFFSET_W-1:0]     rsp_tdata;        // match_offset
   logic                    rsp_tuser;        // match_found

   kmp_pattern_matcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [2*WORD_W-1:0]  pattern_word = '0;
   logic [COUNT_W-1:0]   length_reg = 5'd1;
   logic [COUNT_W-1:0]   fallback_table [16];
   logic [COUNT_W-1:0]   run_count = '0;
   logic [OFFSET_W-1:0]  text_pos = '0;

   match_result_type     expected_matches [$];
   match_result_type     head_match;
   int unsigned          fail_count = 0;
   int unsigned          idle_cycles = 0;
   int unsigned          rsp_wait = 0;
   int unsigned          rsp_draw;
   bit                   rsp_stall_on = 1'b1;
   bit                   req_gaps_on = 1'b1;

   function automatic int unsigned effective_length();
      if (length_reg == 0) return 1;
      if (length_reg > 16) return 16;
      return 32'(length_reg);
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_at(int unsigned i);
      return pattern_word[(i & 15) * BYTE_W +: BYTE_W];
   endfunction

   function automatic void rebuild_fallback();
      int unsigned len;
      int unsigned pre;
      int unsigned cur;
      len = effective_length();
      pre = 0;
      cur = 1;
      foreach (fallback_table[i]) fallback_table[i] = '0;
      while (cur < len) begin
         if (pattern_at(cur) == pattern_at(pre)) begin
            pre++;
            fallback_table[cur] = COUNT_W'(pre);
            cur++;
         end else if (pre != 0) begin
            pre = 32'(fallback_table[pre - 1]);
         end else begin
            cur++;
         end
      end
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
         REG_PATTERN_LOW: begin
            pattern_word[WORD_W-1:0] = data;
         end
         REG_PATTERN_HIGH: begin
            pattern_word[2*WORD_W-1:WORD_W] = data;
         end
         REG_PATTERN_LENGTH: begin
            length_reg = data[COUNT_W-1:0];
         end
         default: begin
            return;
         end
      endcase
      rebuild_fallback();
      run_count = '0;
   endfunction

   function automatic match_result_type scan_byte(logic [BYTE_W-1:0] b, logic start);
      match_result_type r;
      int unsigned len;
      len = effective_length();
      r = '0;
      if (start) begin
         run_count = '0;
         text_pos = '0;
      end
      if (run_count >= len) run_count = '0;
      while (run_count > 0 && pattern_at(run_count) != b)
         run_count = fallback_table[(run_count - 1) % 16];
      if (pattern_at(run_count) == b) run_count++;
      if (run_count == len) begin
         r.found = 1'b1;
         r.offset = text_pos + 32'd1 - OFFSET_W'(len);
         run_count = fallback_table[(len - 1) % 16];
      end
      text_pos = text_pos + 32'd1;
      return r;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_matches.size() != 0);
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
      apply_csr(idx, data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_text(logic [BYTE_W-1:0] b, logic start, match_result_type want);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected_matches.push_back(want);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_draw = rsp_stall_on ? $urandom_range(0, 3) : 0;
         rsp_wait   <= rsp_draw;
         rsp_tready <= (rsp_draw == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
               $display("%0t: unexpected beat, expected none, actual found=%0b offset=%0d",
                        $time, rsp_tuser, rsp_tdata);
         end else begin
            head_match = expected_matches.pop_front();
            if (rsp_tuser !== head_match.found) begin
               fail_count++;
               if (fail_count <= PRINT_LIMIT)
                  $display("%0t: match_found expected %0b actual %0b",
                           $time, head_match.found, rsp_tuser);
            end
            if (rsp_tdata !== head_match.offset) begin
               fail_count++;
               if (fail_count <= PRINT_LIMIT)
                  $display("%0t: match_offset expected %0d actual %0d",
                           $time, head_match.offset, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned     random_items;
      int unsigned     phase_no;
      int unsigned     n;
      int unsigned     len;
      int unsigned     nletters;
      int unsigned     pick;
      int unsigned     m;
      logic [BYTE_W-1:0] letters [3];
      logic [BYTE_W-1:0] text_q [$];
      logic [2*WORD_W-1:0] new_pattern;
      logic [WORD_W-1:0] len_data;
      logic [COUNT_W-1:0] len_field;
      bit              small_alphabet;
      bit              wr_low;
      bit              wr_high;
      bit              wr_len;
      logic            start;
      match_result_type want;

      random_items = 0;
      phase_no = 0;
      rebuild_fallback();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) begin
            if (!csr_valid) wait_drained();
            write_csr(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            want = scan_byte(DIRECTED_ROWS[i].text, DIRECTED_ROWS[i].start);
            if (DIRECTED_ROWS[i].typed) begin
               want.found  = DIRECTED_ROWS[i].found;
               want.offset = DIRECTED_ROWS[i].offset;
            end
            send_text(DIRECTED_ROWS[i].text, DIRECTED_ROWS[i].start, want);
         end
      end

      while (random_items < TEXT_ITEMS) begin
         wait_drained();
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         req_gaps_on  = ($urandom_range(0, 3) != 0);

         small_alphabet = ($urandom_range(0, 3) != 0);
         nletters = $urandom_range(2, 3);
         foreach (letters[i]) letters[i] = BYTE_W'($urandom);
         for (int k = 0; k < 16; k++)
            new_pattern[k*BYTE_W +: BYTE_W] = small_alphabet ?
               letters[$urandom_range(0, nletters - 1)] : BYTE_W'($urandom);

         case ($urandom_range(0, 7))
            0: len_field = 5'd1;
            1: len_field = 5'd16;
            2: len_field = 5'd0;
            3: len_field = COUNT_W'($urandom_range(17, 31));
            default: len_field = COUNT_W'($urandom_range(2, 15));
         endcase
         len_data = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 0) len_data = '0;
         len_data[COUNT_W-1:0] = len_field;

         wr_low  = ($urandom_range(0, 3) != 0);
         wr_high = ($urandom_range(0, 3) != 0);
         wr_len  = ($urandom_range(0, 3) != 0) || (!wr_low && !wr_high);
         if (wr_low)  write_csr(REG_PATTERN_LOW, new_pattern[WORD_W-1:0]);
         if (wr_high) write_csr(REG_PATTERN_HIGH, new_pattern[2*WORD_W-1:WORD_W]);
         if (wr_len)  write_csr(REG_PATTERN_LENGTH, len_data);
         csr_valid <= 1'b0;

         // text: mostly pattern copies, some broken, with alphabet and noise bytes
         len = effective_length();
         n = $urandom_range(20, 90);
         text_q.delete();
         while (text_q.size() < n) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
               for (int k = 0; k < len; k++) text_q.push_back(pattern_at(k));
               if ($urandom_range(0, 3) == 0) begin
                  m = $urandom_range(0, len - 1);
                  text_q[text_q.size() - 1 - m] = letters[$urandom_range(0, nletters - 1)];
               end
            end else if (pick < 17) begin
               text_q.push_back(letters[$urandom_range(0, nletters - 1)]);
            end else begin
               text_q.push_back(BYTE_W'($urandom));
            end
         end

         foreach (text_q[i]) begin
            if (i == text_q.size() / 2 && (phase_no == 0 || $urandom_range(0, 3) == 0))
               wait_drained();
            start = (i == 0 && $urandom_range(0, 1) == 1) || ($urandom_range(0, 24) == 0);
            want = scan_byte(text_q[i], start);
            send_text(text_q[i], start, want);
         end
         random_items += text_q.size();
         phase_no++;
      end

      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
